FILE: sv/deq_pkg.sv
// deq_pkg: transaction types and operation codes of the double-ended queue
// used by double_ended_queue_top and deq_checker; no dependencies

package deq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_STATUS     = 3'd6;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]                action;
        logic signed [VALUE_W-1:0] push_value;
    } t_deq_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      was_empty;
        logic                      overflowed;
        logic [COUNT_W-1:0]        entry_count;
    } t_deq_out;

endpackage

FILE: sv/double_ended_queue_top.sv
// double_ended_queue_top: bounded deque held in a ring buffer memory
// depends on deq_pkg
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------
//   request  | i_in_valid / o_in_ready    | i_in_data  (t_deq_in)
//   result   | o_out_valid / i_out_ready  | o_out_data (t_deq_out)
//
// one transaction per cycle while no result is stalled; a result passes
// through the registered read of the entry memory and then the output
// register. pointers and count update at acceptance, so a read
// never meets a write of the same entry in one cycle.
// synchronous active-low reset clears pointers, count and valid flags.
// a stalled result holds the read stage; requests stop only then.

module double_ended_queue_top #(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  deq_pkg::t_deq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output deq_pkg::t_deq_out o_out_data
);
    import deq_pkg::*;

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_data;

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic                      r_s1_valid;
    logic                      r_s1_use_mem;
    logic signed [VALUE_W-1:0] r_s1_const;
    logic                      r_s1_empty;
    logic                      r_s1_over;
    logic [COUNT_W-1:0]        r_s1_count;

    logic     r_out_valid;
    t_deq_out r_out;

    logic                      accept;
    logic                      advance;
    logic                      is_empty;
    logic                      is_full;
    logic [PW-1:0]             head_inc, head_dec, tail_inc, tail_dec;
    logic                      mem_we, mem_re;
    logic [PW-1:0]             mem_waddr, mem_raddr;
    logic                      n_use_mem;
    logic signed [VALUE_W-1:0] n_const;
    logic                      n_over;
    logic [CW+COUNT_W-1:0]     count_ext;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(CAPACITY));

    assign head_inc = (r_head == PW'(CAPACITY - 1)) ? '0 : r_head + PW'(1);
    assign head_dec = (r_head == '0) ? PW'(CAPACITY - 1) : r_head - PW'(1);
    assign tail_inc = (r_tail == PW'(CAPACITY - 1)) ? '0 : r_tail + PW'(1);
    assign tail_dec = (r_tail == '0) ? PW'(CAPACITY - 1) : r_tail - PW'(1);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_tail;
        mem_raddr = r_head;
        n_use_mem = 1'b0;
        n_const   = '0;
        n_over    = 1'b0;
        case (i_in_data.action)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_over = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = head_dec;
                    n_head    = head_dec;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_over = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_tail;
                    n_tail    = tail_inc;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (is_empty) begin
                    n_const = EMPTY_VALUE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head;
                    n_use_mem = 1'b1;
                    if (i_in_data.action == OP_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (is_empty) begin
                    n_const = EMPTY_VALUE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = tail_dec;
                    n_use_mem = 1'b1;
                    if (i_in_data.action == OP_POP_BACK) begin
                        n_tail  = tail_dec;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_STATUS: begin
                n_const = '0;
            end
            default: begin
                n_const = '0;
            end
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[mem_waddr] <= i_in_data.push_value;
        end
        if (accept && mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_mem <= n_use_mem;
            r_s1_const   <= n_const;
            r_s1_empty   <= is_empty;
            r_s1_over    <= n_over;
            r_s1_count   <= count_ext[COUNT_W-1:0];
        end
        if (advance) begin
            r_out.read_value  <= r_s1_use_mem ? r_rd_data : r_s1_const;
            r_out.was_empty   <= r_s1_empty;
            r_out.overflowed  <= r_s1_over;
            r_out.entry_count <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/deq_checker.sv
// deq_checker: port-level assertions for double_ended_queue_top, with bind
// depends on deq_pkg and double_ended_queue_top

module deq_checker #(
    parameter int CAPACITY = 1024
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input deq_pkg::t_deq_out o_out_data
);
    import deq_pkg::*;

    localparam int CAP_SEEN = (CAPACITY > 2047) ? 2047 : CAPACITY;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // requests stop only behind a held result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request side stalled without a held result");

    // a dropped push reads nothing and cannot meet an empty deque
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflowed |->
            o_out_data.read_value == 32'sd0 && !o_out_data.was_empty)
        else $error("overflow flag inconsistent");

    // an empty deque holds at most one entry afterwards
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.was_empty |-> o_out_data.entry_count <= 11'd1)
        else $error("count too large after empty deque");

    // count bounded by capacity where it fits the field
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (CAPACITY <= 2047) |->
            o_out_data.entry_count <= COUNT_W'(CAP_SEEN))
        else $error("count above capacity");

endmodule

bind double_ended_queue_top deq_checker #(
    .CAPACITY(CAPACITY)
) u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
